// ----- hdl/rlee_pkg.sv -----
// package: shared types and constants for the radix literal expression evaluator
`timescale 1ns / 1ps
package rlee_pkg;

   // pending operator codes
   typedef enum logic [2:0] {
      OP_NONE = 3'd0,
      OP_ADD  = 3'd1,
      OP_SUB  = 3'd2,
      OP_MUL  = 3'd3,
      OP_DIV  = 3'd4
   } op_type;

   // result status codes
   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_EVEN     = 3'd1,
      ST_OP_NUM   = 3'd2,
      ST_BAD_NUM  = 3'd3,
      ST_NUM_OP   = 3'd4,
      ST_BAD_OP   = 3'd5,
      ST_DIV_ZERO = 3'd6
   } status_type;

   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_X     = 8'h78;
   localparam logic [7:0] CH_B     = 8'h62;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_ONE   = 8'h31;
   localparam logic [7:0] CH_SEVEN = 8'h37;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // commands from controller to datapath
   typedef struct packed {
      logic scan;      // take the presented character into the term scanner
      logic term_end;  // classify the term, latch its value, update parity / error / operator
      logic fold;      // fold the latched term value (non-divide) into the total, or flag a divide by zero
      logic div_start; // load the divider
      logic div_step;  // one divider iteration
      logic div_done;  // write the quotient into the total
      logic clear;     // register the result and return to reset state
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic fold_needed; // latched term is a number to fold with no prior error
      logic div_needed;  // that fold is a divide by a nonzero value
      logic div_last;    // divider on its last iteration
   } stat_type;

endpackage

// ----- hdl/radix_literal_expression_evaluator_core.sv -----
// top level: radix literal expression evaluator
// channel  dir  handshake              payload
// req      in   req_tvalid/req_tready  tdata character, tuser token end, tlast expression end
// rsp      out  rsp_tvalid/rsp_tready  tdata result value [31:0], status [34:32]
// sequencing:
//   characters are taken in the scan state; the last character of a term leads to a fold step
//   a divide by a nonzero value adds VALUE_WIDTH divide steps and a quotient write
//   the expression end moves the result into the output register once that register is
//   empty or the previous result there is being taken
//   req_tready is high only in the character scan state
//   active-high sync reset clears all but divider, term latch; no result pending after reset
`timescale 1ns / 1ps
module radix_literal_expression_evaluator_core #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // character
   input  logic        req_tlast,   // expression end
   input  logic        req_tuser,   // token end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // result value [31:0], status [34:32], zero fill
);
   import rlee_pkg::*;

   cmd_type     cmd;
   stat_type    stat;
   logic [31:0] result_value;
   logic [2:0]  status;

   // controller
   rlee_control u_control (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .token_end(req_tuser),
      .expr_end(req_tlast),
      .rsp_tready(rsp_tready),
      .rsp_tvalid(rsp_tvalid),
      .stat(stat),
      .cmd(cmd)
   );

   // datapath
   rlee_datapath #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .character(req_tdata),
      .cmd(cmd),
      .stat(stat),
      .result_value(result_value),
      .status(status)
   );

   assign rsp_tdata = {5'd0, status, result_value};

   // a waiting result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid) else $error("result dropped");
   // a waiting result keeps its data
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata)) else $error("result changed");
   // handshake outputs are always known
   assert property (@(posedge clock) disable iff (reset)
      !$isunknown({req_tready, rsp_tvalid})) else $error("unknown handshake");
endmodule

// ----- hdl/rlee_datapath.sv -----
// datapath: term scanner, base accumulators, total, iterative divider and result register
`timescale 1ns / 1ps
module rlee_datapath #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             character,
   input  rlee_pkg::cmd_type      cmd,
   output rlee_pkg::stat_type     stat,
   output logic [31:0]            result_value,
   output logic [2:0]             status
);
   import rlee_pkg::*;

   localparam int CW = $clog2(VALUE_WIDTH + 1);
   localparam logic [CW-1:0] LAST_STEP = CW'(VALUE_WIDTH - 1);

   logic [1:0]             pos_ff, pos_in;
   logic [7:0]             lc_ff [3];
   logic [7:0]             lc_in [3];
   logic [3:0]             flags_ff, flags_in;
   logic [VALUE_WIDTH-1:0] acc_ff [4];
   logic [VALUE_WIDTH-1:0] acc_in [4];
   logic [VALUE_WIDTH-1:0] total_ff, total_in;
   op_type                 op_ff, op_in;
   logic                   parity_ff, parity_in;
   logic [2:0]             err_ff, err_in;
   logic                   dz_ff, dz_in;
   // divider state
   logic [VALUE_WIDTH-1:0] quo_ff, quo_in, rem_ff, rem_in, dvs_ff, dvs_in;
   logic                   qneg_ff, qneg_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   // latched term value and fold flag
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic                   fold_ff, fold_in;
   // result register
   logic [31:0]            res_ff;
   logic [2:0]             st_ff;

   // character decode
   logic [7:0]             c0, c1, c2;
   logic                   neg, isdig, ishex;
   logic [3:0]             dv, hv;
   always_comb begin
      c0 = (pos_ff == 2'd0) ? character : lc_ff[0];
      c1 = (pos_ff == 2'd1) ? character : lc_ff[1];
      c2 = (pos_ff == 2'd2) ? character : lc_ff[2];
      neg = (c0 == CH_MINUS);
      isdig = (character >= CH_ZERO) && (character <= CH_NINE);
      dv = isdig ? 4'(character - CH_ZERO) : 4'd0;
      ishex = 1'b1;
      if (isdig) hv = dv;
      else if (character >= 8'h41 && character <= 8'h46) hv = 4'(character - 8'h37);
      else if (character >= 8'h61 && character <= 8'h66) hv = 4'(character - 8'h57);
      else begin
         hv = 4'd0;
         ishex = 1'b0;
      end
   end

   // scanner update for the presented character
   always_comb begin
      lc_in = lc_ff;
      flags_in = flags_ff;
      acc_in = acc_ff;
      if (pos_ff != 2'd3) lc_in[pos_ff] = character;
      if (pos_ff >= (neg ? 2'd1 : 2'd0)) begin
         if (!isdig) flags_in[0] = 1'b0;
         acc_in[0] = VALUE_WIDTH'(acc_ff[0] * VALUE_WIDTH'(10)) + VALUE_WIDTH'(dv);
      end
      if (pos_ff >= (neg ? 2'd3 : 2'd2)) begin
         if (character != CH_ZERO && character != CH_ONE) flags_in[1] = 1'b0;
         acc_in[1] = {acc_ff[1][VALUE_WIDTH-2:0], dv[0]};
         if (!ishex) flags_in[3] = 1'b0;
         acc_in[3] = {acc_ff[3][VALUE_WIDTH-5:0], hv};
      end
      if (pos_ff >= (neg ? 2'd2 : 2'd1)) begin
         if (character < CH_ZERO || character > CH_SEVEN) flags_in[2] = 1'b0;
         acc_in[2] = {acc_ff[2][VALUE_WIDTH-4:0], dv[2:0]};
      end
      pos_in = (pos_ff == 2'd3) ? pos_ff : pos_ff + 2'd1;
   end

   // term classification, using the state as it stands after this character
   logic                   is_dec, is_bin, is_oct, is_hex, is_num, is_op;
   logic [VALUE_WIDTH-1:0] val;
   op_type                 opc;
   logic [1:0]             p;
   always_comb begin
      p = pos_ff;
      is_dec = flags_in[0] &&
               (neg ? (p >= 2'd1 && c1 != CH_ZERO) : (c0 != CH_ZERO || p == 2'd0));
      is_bin = flags_in[1] && ((!neg && c0 == CH_ZERO && c1 == CH_B && p >= 2'd2)
                            || (neg && c1 == CH_ZERO && c2 == CH_B && p == 2'd3));
      is_hex = flags_in[3] && ((!neg && c0 == CH_ZERO && c1 == CH_X && p >= 2'd2)
                            || (neg && c1 == CH_ZERO && c2 == CH_X && p == 2'd3));
      is_oct = flags_in[2] &&
               ((!neg && c0 == CH_ZERO && p >= 2'd1 && c1 != CH_X && c1 != CH_B)
             || (neg && c1 == CH_ZERO && p >= 2'd2 && c2 != CH_X && c2 != CH_B));
      is_num = is_dec || is_bin || is_oct || is_hex;
      priority if (is_dec) val = acc_in[0];
      else if (is_bin) val = acc_in[1];
      else if (is_oct) val = acc_in[2];
      else if (is_hex) val = acc_in[3];
      else val = '0;
      if (neg) val = VALUE_WIDTH'(0) - val;
      is_op = 1'b0;
      opc = OP_NONE;
      if (p == 2'd0) begin
         priority if (c0 == CH_PLUS) begin opc = OP_ADD; is_op = 1'b1; end
         else if (c0 == CH_MINUS) begin opc = OP_SUB; is_op = 1'b1; end
         else if (c0 == CH_STAR || c0 == CH_DOT) begin opc = OP_MUL; is_op = 1'b1; end
         else if (c0 == CH_SLASH) begin opc = OP_DIV; is_op = 1'b1; end
         else is_op = 1'b0;
      end
   end

   assign stat.fold_needed = fold_ff;
   assign stat.div_needed  = (op_ff == OP_DIV) && (val_ff != '0);
   assign stat.div_last    = (cnt_ff == LAST_STEP);

   // restoring divide step
   logic [VALUE_WIDTH:0]   trial;
   logic [VALUE_WIDTH-1:0] rsh;
   assign rsh = {rem_ff[VALUE_WIDTH-2:0], quo_ff[VALUE_WIDTH-1]};
   assign trial = {1'b0, rsh} - {1'b0, dvs_ff};

   // next state
   always_comb begin
      total_in = total_ff;
      op_in = op_ff;
      parity_in = parity_ff;
      err_in = err_ff;
      dz_in = dz_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      qneg_in = qneg_ff;
      cnt_in = cnt_ff;
      val_in = val_ff;
      fold_in = fold_ff;
      if (cmd.fold) begin
         unique case (op_ff)
            OP_SUB: total_in = total_ff - val_ff;
            OP_MUL: total_in = VALUE_WIDTH'(total_ff * val_ff);
            OP_DIV: dz_in = 1'b1;
            default: total_in = total_ff + val_ff;
         endcase
      end
      if (cmd.term_end) begin
         val_in = val;
         fold_in = !parity_ff && is_num && (err_ff == 3'd0);
         if (!parity_ff) begin
            if (!is_num && err_ff == 3'd0) err_in = is_op ? ST_OP_NUM : ST_BAD_NUM;
         end else if (is_op) begin
            op_in = opc;
         end else if (err_ff == 3'd0) begin
            err_in = is_num ? ST_NUM_OP : ST_BAD_OP;
         end
         parity_in = !parity_ff;
      end
      if (cmd.div_start) begin
         quo_in = total_ff[VALUE_WIDTH-1] ? VALUE_WIDTH'(0) - total_ff : total_ff;
         dvs_in = val_ff[VALUE_WIDTH-1] ? VALUE_WIDTH'(0) - val_ff : val_ff;
         rem_in = '0;
         qneg_in = total_ff[VALUE_WIDTH-1] ^ val_ff[VALUE_WIDTH-1];
         cnt_in = '0;
      end
      if (cmd.div_step) begin
         if (!trial[VALUE_WIDTH]) begin
            rem_in = trial[VALUE_WIDTH-1:0];
            quo_in = {quo_ff[VALUE_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = rsh;
            quo_in = {quo_ff[VALUE_WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CW'(1);
      end
      if (cmd.div_done) total_in = qneg_ff ? VALUE_WIDTH'(0) - quo_ff : quo_ff;
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         pos_ff <= '0;
         lc_ff <= '{default: '0};
         flags_ff <= '1;
         acc_ff <= '{default: '0};
         total_ff <= '0;
         op_ff <= OP_NONE;
         parity_ff <= 1'b0;
         err_ff <= '0;
         dz_ff <= 1'b0;
         fold_ff <= 1'b0;
      end else begin
         if (cmd.scan) begin
            if (cmd.term_end) begin
               pos_ff <= '0;
               lc_ff <= '{default: '0};
               flags_ff <= '1;
               acc_ff <= '{default: '0};
            end else begin
               pos_ff <= pos_in;
               lc_ff <= lc_in;
               flags_ff <= flags_in;
               acc_ff <= acc_in;
            end
         end
         total_ff <= total_in;
         op_ff <= op_in;
         parity_ff <= parity_in;
         err_ff <= err_in;
         dz_ff <= dz_in;
         fold_ff <= fold_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      qneg_ff <= qneg_in;
      cnt_ff <= cnt_in;
      val_ff <= val_in;
   end

   // final status, read after the last term has been folded
   logic [2:0]  st_now;
   logic [31:0] res_now;
   always_comb begin
      if (!parity_ff) st_now = ST_EVEN;
      else if (err_ff != 3'd0) st_now = err_ff;
      else if (dz_ff) st_now = ST_DIV_ZERO;
      else st_now = ST_OK;
      res_now = (st_now == ST_OK) ? 32'(total_ff) : 32'd0;
   end

   // result register, loaded as the evaluator returns to reset state
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
         res_ff <= '0;
      end else if (cmd.clear) begin
         st_ff <= st_now;
         res_ff <= res_now;
      end
   end
   assign status = st_ff;
   assign result_value = res_ff;

   // divider divisor is never zero while iterating
   assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> dvs_ff != '0) else $error("divide by zero in divider");
   // a divide is only started on a divide operator
   assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> op_ff == OP_DIV) else $error("divide without divide operator");
   // latched divisor is nonzero when the quotient is written
   assert property (@(posedge clock) disable iff (reset)
      cmd.div_done |-> val_ff != '0) else $error("quotient with zero divisor");
endmodule

// ----- hdl/rlee_control.sv -----
// controller: sequences character scan, fold, divide iterations and result output
`timescale 1ns / 1ps
module rlee_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                token_end,
   input  logic                expr_end,
   input  logic                rsp_tready,
   output logic                rsp_tvalid,
   input  rlee_pkg::stat_type  stat,
   output rlee_pkg::cmd_type   cmd
);
   import rlee_pkg::*;

   typedef enum logic [2:0] {S_SCAN, S_FOLD, S_DIV, S_QUOT, S_OUT} state_type;
   state_type state_ff, state_in;
   logic      eend_ff, eend_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      acc;

   assign req_tready = (state_ff == S_SCAN);
   assign rsp_tvalid = rsp_valid_ff;
   assign acc = req_tvalid && req_tready;

   // command decode and next state
   always_comb begin
      cmd = '0;
      state_in = state_ff;
      eend_in = eend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         S_SCAN: begin
            if (acc) begin
               cmd.scan = 1'b1;
               if (token_end || expr_end) begin
                  cmd.term_end = 1'b1;
                  eend_in = expr_end;
                  state_in = S_FOLD;
               end
            end
         end
         S_FOLD: begin
            if (stat.fold_needed && stat.div_needed) begin
               cmd.div_start = 1'b1;
               state_in = S_DIV;
            end else begin
               cmd.fold = stat.fold_needed;
               state_in = eend_ff ? S_OUT : S_SCAN;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) state_in = S_QUOT;
         end
         S_QUOT: begin
            cmd.div_done = 1'b1;
            state_in = eend_ff ? S_OUT : S_SCAN;
         end
         S_OUT: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.clear = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = S_SCAN;
            end
         end
         default: state_in = S_SCAN;
      endcase
   end

   // state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SCAN;
         eend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         eend_ff <= eend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule
